@@ sv/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, constants and helpers of the climate sensor compensation core.
// ----------------------------------------------------------------------------
package csc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_TRIM    = 3'd0;
    localparam logic [2:0] REG_PRESS_TRIM_A = 3'd1;
    localparam logic [2:0] REG_PRESS_TRIM_B = 3'd2;
    localparam logic [2:0] REG_PRESS_TRIM_C = 3'd3;
    localparam logic [2:0] REG_HUM_TRIM     = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // special raw codes
    localparam logic [19:0] RAW_T_NONE = 20'h80000;
    localparam logic [15:0] RAW_H_NONE = 16'h8000;

    // compensation constants
    localparam logic [31:0] P_OFS      = 32'd64000;
    localparam logic [31:0] H_OFS      = 32'd76800;
    localparam logic [31:0] H_MAX      = 32'd419430400;
    localparam logic [31:0] P_SCALE    = 32'd3125;
    localparam logic [31:0] P_BASE     = 32'd1048576;
    localparam logic [31:0] P_MIN      = 32'd30000;
    localparam logic [31:0] P_MAX      = 32'd110000;
    localparam logic [31:0] T_MIN      = -32'sd4000;
    localparam logic [31:0] T_MAX      = 32'd8500;
    localparam logic [10:0] HPA_NODIV  = 11'd300;
    // ceil(2^32 / 100), exact quotient for values below 2^17
    localparam logic [25:0] RECIP_100  = 26'd42949673;

    // pipeline depth: front end, divider, back end
    localparam int FRONT_STG = 13;
    localparam int DIV_STG   = 32;
    localparam int BACK_STG  = 4;
    localparam int NUM_STG   = FRONT_STG + DIV_STG + BACK_STG;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_in_word;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [10:0]        pressure_hpa;
        logic [6:0]         humidity_percent;
        logic               temperature_ok;
        logic               humidity_ok;
    } t_out_word;

    // side data that travels with each word down the pipeline
    typedef struct packed {
        logic        tok;
        logic        hok;
        logic [19:0] rp;
        logic [15:0] rh;
        logic [14:0] temp;
        logic [6:0]  hum;
        logic [10:0] hpa;
        logic        zdiv;
        logic        post;
    } t_ctx;

    // arithmetic shift right on a 32-bit pattern
    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = 32'($signed(x) >>> n);
    endfunction

    // wrapping 32-bit product
    function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        mul = p[31:0];
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        sx16 = {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] x);
        sx12 = {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        sx8 = {{24{x[7]}}, x};
    endfunction

endpackage

@@ sv/climate_sensor_compensation_core.sv @@
// ----------------------------------------------------------------------------
// climate_sensor_compensation_core
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// A fully pipelined unit: one reading is taken in every cycle (busy stays
// low) and its result appears with o_strobe at the end of the pipeline, for
// one cycle; the receiver cannot hold results off. The pipeline is made of a
// 13-stage front end (temperature, pressure and humidity terms), a 32-stage
// restoring divider for the pressure quotient, one bit per stage, and a
// 4-stage pressure back end. Trim registers are written through the plain
// write port and must only change while no reading is in flight.
module climate_sensor_compensation_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  csc_pkg::t_in_word                   i_data,
    output logic                                o_strobe,
    output csc_pkg::t_out_word                  o_result,
    input  logic                                i_cfg_we,
    input  logic [csc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [csc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import csc_pkg::*;

    localparam int DIV0 = FRONT_STG;
    localparam int DEND = FRONT_STG + DIV_STG;

    // trim registers
    logic [47:0] r_ttrim, r_pa, r_pb, r_pc;
    logic [63:0] r_htrim;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttrim <= '0;
            r_pa    <= '0;
            r_pb    <= '0;
            r_pc    <= '0;
            r_htrim <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEMP_TRIM:    r_ttrim <= i_cfg_data[47:0];
                REG_PRESS_TRIM_A: r_pa    <= i_cfg_data[47:0];
                REG_PRESS_TRIM_B: r_pb    <= i_cfg_data[47:0];
                REG_PRESS_TRIM_C: r_pc    <= i_cfg_data[47:0];
                REG_HUM_TRIM:     r_htrim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // trim fields
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    assign t1 = {16'b0, r_ttrim[15:0]};
    assign t2 = sx16(r_ttrim[31:16]);
    assign t3 = sx16(r_ttrim[47:32]);
    assign p1 = {16'b0, r_pa[15:0]};
    assign p2 = sx16(r_pa[31:16]);
    assign p3 = sx16(r_pa[47:32]);
    assign p4 = sx16(r_pb[15:0]);
    assign p5 = sx16(r_pb[31:16]);
    assign p6 = sx16(r_pb[47:32]);
    assign p7 = sx16(r_pc[15:0]);
    assign p8 = sx16(r_pc[31:16]);
    assign p9 = sx16(r_pc[47:32]);
    assign h1 = {24'b0, r_htrim[7:0]};
    assign h2 = sx16(r_htrim[23:8]);
    assign h3 = {24'b0, r_htrim[31:24]};
    assign h4 = sx12(r_htrim[43:32]);
    assign h5 = sx12(r_htrim[55:44]);
    assign h6 = sx8(r_htrim[63:56]);

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits and side data per stage
    logic [NUM_STG:1] r_vld;
    t_ctx             r_ctx [1:NUM_STG];
    t_ctx             n_ctx [1:NUM_STG-1];
    t_ctx             n_ctx0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NUM_STG-1:1], accept};
        end
    end

    always_comb begin
        n_ctx0      = '0;
        n_ctx0.tok  = (i_data.raw_temperature != RAW_T_NONE);
        n_ctx0.hok  = n_ctx0.tok && (i_data.raw_humidity != RAW_H_NONE);
        n_ctx0.rp   = i_data.raw_pressure;
        n_ctx0.rh   = i_data.raw_humidity;
    end

    always_ff @(posedge i_clk) begin
        r_ctx[1] <= n_ctx0;
        for (int k = 2; k <= NUM_STG; k++) begin
            r_ctx[k] <= n_ctx[k-1];
        end
    end

    // temperature front: stage 1
    logic [31:0] r1_a, r1_b;
    always_ff @(posedge i_clk) begin
        r1_a <= (32'(i_data.raw_temperature) >> 3) - (t1 << 1);
        r1_b <= (32'(i_data.raw_temperature) >> 4) - t1;
    end

    // stages 2 to 4: fine temperature
    logic [31:0] r2_ma, r2_mb, r3_a, r3_m, r4_tf;
    always_ff @(posedge i_clk) begin
        r2_ma <= mul(r1_a, t2);
        r2_mb <= mul(r1_b, r1_b);
        r3_a  <= asr(r2_ma, 11);
        r3_m  <= mul(asr(r2_mb, 12), t3);
        r4_tf <= r3_a + asr(r3_m, 14);
    end

    // stage 5: temperature output and offsets
    logic [31:0] tcalc, tclamp;
    logic [31:0] r5_pa, r5_q, r5_ha;
    always_comb begin
        tcalc  = asr(mul(r4_tf, 32'd5) + 32'd128, 8);
        tclamp = tcalc;
        if ($signed(tcalc) < $signed(T_MIN)) tclamp = T_MIN;
        if ($signed(tcalc) > $signed(T_MAX)) tclamp = T_MAX;
    end
    always_ff @(posedge i_clk) begin
        r5_pa <= asr(r4_tf, 1) - P_OFS;
        r5_q  <= asr(asr(r4_tf, 1) - P_OFS, 2);
        r5_ha <= r4_tf - H_OFS;
    end

    // stage 6: first products
    logic [31:0] r6_qq, r6_ap5, r6_p2a, r6_x, r6_hd, r6_bh, r6_ch;
    always_ff @(posedge i_clk) begin
        r6_qq  <= mul(r5_q, r5_q);
        r6_ap5 <= mul(r5_pa, p5);
        r6_p2a <= mul(p2, r5_pa);
        r6_x   <= (32'(r_ctx[5].rh) << 14) - (h4 << 20);
        r6_hd  <= mul(h5, r5_ha);
        r6_bh  <= mul(r5_ha, h6);
        r6_ch  <= mul(r5_ha, h3);
    end

    // stage 7
    logic [31:0] r7_b1, r7_c1, r7_ap5, r7_p2a, r7_e, r7_b2, r7_c2;
    always_ff @(posedge i_clk) begin
        r7_b1  <= mul(asr(r6_qq, 11), p6);
        r7_c1  <= mul(p3, asr(r6_qq, 13));
        r7_ap5 <= r6_ap5;
        r7_p2a <= r6_p2a;
        r7_e   <= asr(r6_x - r6_hd + 32'd16384, 15);
        r7_b2  <= asr(r6_bh, 10);
        r7_c2  <= asr(r6_ch, 11) + 32'd32768;
    end

    // stage 8
    logic [31:0] r8_b, r8_a, r8_m, r8_e;
    always_ff @(posedge i_clk) begin
        r8_b <= asr(r7_b1 + (r7_ap5 << 1), 2) + (p4 << 16);
        r8_a <= asr(asr(r7_c1, 3) + asr(r7_p2a, 1), 18);
        r8_m <= mul(r7_b2, r7_c2);
        r8_e <= r7_e;
    end

    // stage 9
    logic [31:0] r9_m, r9_b, r9_md, r9_e;
    always_ff @(posedge i_clk) begin
        r9_m  <= mul(32'd32768 + r8_a, p1);
        r9_b  <= r8_b;
        r9_md <= mul(asr(r8_m, 10) + 32'd2097152, h2);
        r9_e  <= r8_e;
    end

    // stage 10: divisor and numerator
    logic [31:0] r10_div, r10_num, r10_c;
    always_ff @(posedge i_clk) begin
        r10_div <= asr(r9_m, 15);
        r10_num <= (P_BASE - 32'(r_ctx[9].rp)) - asr(r9_b, 12);
        r10_c   <= mul(r9_e, asr(r9_md + 32'd8192, 14));
    end

    // stage 11
    logic [31:0] r11_p, r11_div, r11_ss, r11_c;
    always_ff @(posedge i_clk) begin
        r11_p   <= mul(r10_num, P_SCALE);
        r11_div <= r10_div;
        r11_ss  <= mul(asr(r10_c, 15), asr(r10_c, 15));
        r11_c   <= r10_c;
    end

    // stage 12: dividend setup
    logic [31:0] r12_n, r12_div, r12_hm, r12_c;
    always_ff @(posedge i_clk) begin
        r12_n   <= r11_p[31] ? r11_p : (r11_p << 1);
        r12_div <= r11_div;
        r12_hm  <= mul(asr(r11_ss, 7), h1);
        r12_c   <= r11_c;
    end

    // stage 12 humidity finish
    logic [31:0] he, hclamp;
    always_comb begin
        he     = r12_c - asr(r12_hm, 4);
        hclamp = he;
        if ($signed(he) < 0) hclamp = '0;
        if ($signed(he) > $signed(H_MAX)) hclamp = H_MAX;
    end

    // divider: one quotient bit per stage
    logic [31:0] r_dn [DIV0:DEND];
    logic [31:0] r_dr [DIV0:DEND];
    logic [31:0] r_dq [DIV0:DEND];
    logic [31:0] r_dd [DIV0:DEND];

    always_ff @(posedge i_clk) begin
        r_dn[DIV0] <= r12_n;
        r_dr[DIV0] <= '0;
        r_dq[DIV0] <= '0;
        r_dd[DIV0] <= r12_div;
    end

    for (genvar k = DIV0 + 1; k <= DEND; k++) begin : g_div
        logic [32:0] trial;
        logic        ge;
        assign trial = {r_dr[k-1], r_dn[k-1][31]};
        assign ge    = (trial >= {1'b0, r_dd[k-1]});
        always_ff @(posedge i_clk) begin
            r_dn[k] <= r_dn[k-1] << 1;
            r_dr[k] <= ge ? 32'(trial - {1'b0, r_dd[k-1]}) : trial[31:0];
            r_dq[k] <= {r_dq[k-1][30:0], ge};
            r_dd[k] <= r_dd[k-1];
        end
    end

    // back end stage 1: quotient fixup and products
    logic [31:0] qp;
    logic [31:0] rb1_p, rb1_pp, rb1_b8;
    assign qp = r_ctx[DEND].post ? (r_dq[DEND] << 1) : r_dq[DEND];
    always_ff @(posedge i_clk) begin
        rb1_p  <= qp;
        rb1_pp <= mul(qp >> 3, qp >> 3);
        rb1_b8 <= mul(qp >> 2, p8);
    end

    // back end stage 2
    logic [31:0] rb2_p, rb2_am, rb2_b8;
    always_ff @(posedge i_clk) begin
        rb2_p  <= rb1_p;
        rb2_am <= mul(p9, rb1_pp >> 13);
        rb2_b8 <= rb1_b8;
    end

    // back end stage 3: correction and clamp
    logic [31:0] pfin, pcl;
    logic [16:0] rb3_pc;
    always_comb begin
        pfin = rb2_p + asr(asr(rb2_am, 12) + asr(rb2_b8, 13) + p7, 4);
        pcl  = pfin;
        if (pfin < P_MIN) pcl = P_MIN;
        if (pfin > P_MAX) pcl = P_MAX;
    end
    always_ff @(posedge i_clk) begin
        rb3_pc <= pcl[16:0];
    end

    // back end stage 4: divide by 100 via reciprocal
    logic [42:0] hprod;
    assign hprod = 43'(rb3_pc) * 43'(RECIP_100);

    // side data updates where values become known
    always_comb begin
        for (int k = 1; k < NUM_STG; k++) begin
            n_ctx[k] = r_ctx[k];
        end
        n_ctx[4].temp  = r_ctx[4].tok ? tclamp[14:0] : '0;
        n_ctx[11].zdiv = (r11_div == '0);
        n_ctx[11].post = r11_p[31];
        n_ctx[12].hum  = r_ctx[12].hok ? hclamp[28:22] : '0;
        if (!r_ctx[NUM_STG-1].tok) begin
            n_ctx[NUM_STG-1].hpa = '0;
        end else if (r_ctx[NUM_STG-1].zdiv) begin
            n_ctx[NUM_STG-1].hpa = HPA_NODIV;
        end else begin
            n_ctx[NUM_STG-1].hpa = hprod[42:32];
        end
    end

    // result word
    assign o_strobe                   = r_vld[NUM_STG];
    assign o_result.temperature_centi = r_ctx[NUM_STG].temp;
    assign o_result.pressure_hpa      = r_ctx[NUM_STG].hpa;
    assign o_result.humidity_percent  = r_ctx[NUM_STG].hum;
    assign o_result.temperature_ok    = r_ctx[NUM_STG].tok;
    assign o_result.humidity_ok       = r_ctx[NUM_STG].hok;

    // checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##NUM_STG o_strobe)
        else $error("word lost in pipeline");

    a_hum_needs_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.humidity_ok |-> o_result.temperature_ok)
        else $error("humidity valid without temperature");

    a_press_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.temperature_ok |->
            o_result.pressure_hpa >= 11'd300 && o_result.pressure_hpa <= 11'd1100)
        else $error("pressure out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.temperature_ok |->
            o_result.pressure_hpa == '0 && o_result.temperature_centi == '0 &&
            o_result.humidity_percent == '0)
        else $error("invalid word not cleared");

endmodule
